// File: hw/rtl/rkfs_pkg.sv
// Package for the RGB keyframe fade sequencer.
// Holds the transaction payload types, the keyframe entry layout and the action codes.
// It has no dependencies.
package rkfs_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 32;
  localparam int unsigned IDX_IN_W = 5;
  localparam int unsigned IDX_IN_CODES = 1 << IDX_IN_W;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_SELECT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [IDX_IN_W-1:0] entry_index;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          red_step;
    logic [7:0]          green_step;
    logic [7:0]          blue_step;
    logic [IDX_IN_W-1:0] seq_first;
    logic [IDX_IN_W-1:0] seq_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       advanced;
  } out_item_t;

  typedef struct packed {
    logic [2:0][7:0] color;
    logic [2:0][7:0] step;
  } kf_entry_t;

endpackage

// File: hw/rtl/rgb_keyframe_fade_sequencer_core.sv
// Top level of the RGB keyframe fade sequencer.
// Keeps the keyframe store in two mirrored synchronous memories; uses rkfs_pkg.
//
// A tick result is registered into the output during the EXEC state that follows
// the tick's acceptance. A tick passes through EXEC, then LOAD when it advances,
// LOAD being the memory read that reloads the color; a select passes through LOAD.
// The synchronous read ports require LOAD. Reset is asynchronous and clears
// the indexes, range and color; the store itself is not cleared.
module rgb_keyframe_fade_sequencer_core #(
  parameter int unsigned ENTRIES = rkfs_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rkfs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rkfs_pkg::out_item_t out_data_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned IN_CODES = rkfs_pkg::IDX_IN_CODES;

  function automatic logic [IN_CODES*IW-1:0] build_mod_lut();
    logic [IN_CODES*IW-1:0] lut;
    int v;
    lut = '0;
    for (int i = 0; i < IN_CODES; i++) begin
      v = i;
      while (v >= int'(ENTRIES)) begin
        v = v - int'(ENTRIES);
      end
      lut[i*IW +: IW] = IW'(v);
    end
    return lut;
  endfunction

  localparam logic [IN_CODES*IW-1:0] MOD_LUT = build_mod_lut();

  function automatic logic [IW-1:0] next_in_range(logic [IW-1:0] idx, logic [IW-1:0] first,
                                                   logic [IW-1:0] last);
    logic [IW:0] n;
    n = {1'b0, idx} + (IW+1)'(1);
    if (n > {1'b0, last}) begin
      return first;
    end
    return n[IW-1:0];
  endfunction

  rkfs_pkg::kf_entry_t mem_a [ENTRIES];
  rkfs_pkg::kf_entry_t mem_b [ENTRIES];
  rkfs_pkg::kf_entry_t rd_a_q, rd_b_q, wr_entry;

  rkfs_pkg::state_e    state_q, state_d;
  logic [2:0][7:0]     color_q, color_d;
  logic [IW-1:0]       from_q, from_d, to_q, to_d, first_q, first_d, last_q, last_d;
  logic                out_valid_q, out_valid_d;
  rkfs_pkg::out_item_t out_q, out_d;

  logic                accept;
  logic                wr_en;
  logic [8:0]          wr_index_wide;
  logic [IW-1:0]       wr_addr, rd_addr_a, sel_first, sel_last;
  logic [IW:0]         sel_next;
  logic [2:0][7:0]     stepped;
  logic [7:0]          delta;
  logic                reached, all_equal, adv;
  logic [IW-1:0]       next_from;

  assign in_stall_o  = (state_q != rkfs_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_index_wide = 9'(in_data_i.entry_index);
  assign wr_addr       = wr_index_wide[IW-1:0];
  assign wr_en         = accept && (in_data_i.action == rkfs_pkg::ACT_WRITE) &&
                         (wr_index_wide < 9'(ENTRIES));
  assign wr_entry.color = {in_data_i.red, in_data_i.green, in_data_i.blue};
  assign wr_entry.step  = {in_data_i.red_step, in_data_i.green_step, in_data_i.blue_step};

  assign sel_first = MOD_LUT[in_data_i.seq_first*IW +: IW];
  assign sel_last  = MOD_LUT[in_data_i.seq_last*IW +: IW];
  assign sel_next  = {1'b0, sel_first} + (IW+1)'(1);

  always_comb begin
    reached   = 1'b0;
    all_equal = 1'b1;
    delta     = '0;
    for (int c = 0; c < 3; c++) begin
      if (color_q[c] < rd_b_q.color[c]) begin
        stepped[c] = color_q[c] + rd_a_q.step[c];
      end else if (color_q[c] > rd_b_q.color[c]) begin
        stepped[c] = color_q[c] - rd_a_q.step[c];
      end else begin
        stepped[c] = color_q[c];
      end
      delta = (stepped[c] >= rd_b_q.color[c]) ? stepped[c] - rd_b_q.color[c]
                                              : rd_b_q.color[c] - stepped[c];
      if (delta != 8'd0) begin
        all_equal = 1'b0;
        if (delta <= rd_a_q.step[c]) begin
          reached = 1'b1;
        end
      end
    end
    adv       = reached || all_equal;
    next_from = next_in_range(from_q, first_q, last_q);
  end

  always_comb begin
    state_d     = state_q;
    color_d     = color_q;
    from_d      = from_q;
    to_d        = to_q;
    first_d     = first_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_addr_a   = from_q;
    unique case (state_q)
      rkfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.action)
            rkfs_pkg::ACT_TICK: begin
              state_d = rkfs_pkg::ST_EXEC;
            end
            rkfs_pkg::ACT_SELECT: begin
              rd_addr_a = sel_first;
              first_d   = sel_first;
              last_d    = sel_last;
              from_d    = sel_first;
              to_d      = (sel_next == (IW+1)'(ENTRIES)) ? '0 : sel_next[IW-1:0];
              state_d   = rkfs_pkg::ST_LOAD;
            end
            default: begin
            end
          endcase
        end
      end
      rkfs_pkg::ST_EXEC: begin
        out_valid_d        = 1'b1;
        out_d.red_out      = color_q[2];
        out_d.green_out    = color_q[1];
        out_d.blue_out     = color_q[0];
        out_d.advanced     = adv;
        color_d            = stepped;
        if (adv) begin
          rd_addr_a = next_from;
          from_d    = next_from;
          to_d      = next_in_range(to_q, first_q, last_q);
          state_d   = rkfs_pkg::ST_LOAD;
        end else begin
          state_d = rkfs_pkg::ST_IDLE;
        end
      end
      rkfs_pkg::ST_LOAD: begin
        color_d = rd_a_q.color;
        state_d = rkfs_pkg::ST_IDLE;
      end
      default: begin
        state_d = rkfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_entry;
      mem_b[wr_addr] <= wr_entry;
    end
    rd_a_q <= mem_a[rd_addr_a];
    rd_b_q <= mem_b[to_q];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rkfs_pkg::ST_IDLE;
      color_q     <= '0;
      from_q      <= '0;
      to_q        <= IW'(1);
      first_q     <= '0;
      last_q      <= IW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      color_q     <= color_d;
      from_q      <= from_d;
      to_q        <= to_d;
      first_q     <= first_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for rgb_keyframe_fade_sequencer_core: directed and random transactions, with a
// scoreboard class that predicts each tick's color and advance flag. Depends on rkfs_pkg.
module tb;

  localparam int unsigned DEPTH = rkfs_pkg::ENTRIES_DEFAULT;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned PRESSURE_AFTER = 80;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef logic [rkfs_pkg::IDX_IN_W-1:0] idx_t;
  typedef logic [7:0] level_t;

  class fade_scoreboard;
    bit [7:0]    kf_color [DEPTH][3];
    bit [7:0]    kf_step  [DEPTH][3];
    bit          written  [DEPTH];
    bit [7:0]    level    [3];
    int unsigned from_idx, to_idx, rng_first, rng_last;
    rkfs_pkg::out_item_t pending [$];
    int unsigned mismatches, checked, advances, ticks, writes, selects, ignored;

    function new();
      from_idx = 0;
      to_idx = 1 % DEPTH;
      rng_first = 0;
      rng_last = 1 % DEPTH;
      foreach (level[c]) level[c] = 8'd0;
    endfunction

    function int unsigned step_index(int unsigned idx);
      int unsigned n;
      n = idx + 1;
      if (n > rng_last) n = rng_first;
      return n % DEPTH;
    endfunction

    // Returns an entry that the item would read while still unwritten, or -1.
    function int missing_entry(rkfs_pkg::in_item_t it);
      int unsigned probe [3];
      if (it.action == rkfs_pkg::ACT_SELECT) begin
        if (!written[it.seq_first % DEPTH]) return int'(it.seq_first % DEPTH);
      end else if (it.action == rkfs_pkg::ACT_TICK) begin
        probe[0] = from_idx;
        probe[1] = to_idx;
        probe[2] = step_index(from_idx);
        foreach (probe[k]) if (!written[probe[k]]) return int'(probe[k]);
      end
      return -1;
    endfunction

    function void note_input(rkfs_pkg::in_item_t it);
      int unsigned e;
      int c;
      bit [7:0] tgt, st, delta;
      bit all_equal, reached;
      rkfs_pkg::out_item_t want;
      case (it.action)
        rkfs_pkg::ACT_WRITE: begin
          writes++;
          e = it.entry_index;
          if (e < DEPTH) begin
            kf_color[e][0] = it.red;
            kf_color[e][1] = it.green;
            kf_color[e][2] = it.blue;
            kf_step[e][0] = it.red_step;
            kf_step[e][1] = it.green_step;
            kf_step[e][2] = it.blue_step;
            written[e] = 1'b1;
          end
        end
        rkfs_pkg::ACT_SELECT: begin
          selects++;
          rng_first = it.seq_first % DEPTH;
          rng_last = it.seq_last % DEPTH;
          from_idx = rng_first;
          to_idx = (rng_first + 1) % DEPTH;
          level = kf_color[from_idx];
        end
        rkfs_pkg::ACT_TICK: begin
          ticks++;
          want.red_out = level[0];
          want.green_out = level[1];
          want.blue_out = level[2];
          all_equal = 1'b1;
          reached = 1'b0;
          for (c = 0; c < 3; c++) begin
            tgt = kf_color[to_idx][c];
            st = kf_step[from_idx][c];
            if (level[c] < tgt) level[c] = level[c] + st;
            else if (level[c] > tgt) level[c] = level[c] - st;
            delta = (level[c] >= tgt) ? level[c] - tgt : tgt - level[c];
            if (delta != 8'd0) all_equal = 1'b0;
            if (delta != 8'd0 && delta <= st) reached = 1'b1;
          end
          want.advanced = all_equal || reached;
          if (want.advanced) begin
            advances++;
            from_idx = step_index(from_idx);
            to_idx = step_index(to_idx);
            level = kf_color[from_idx];
          end
          pending.push_back(want);
        end
        default: ignored++;
      endcase
    endfunction

    function void check_result(rkfs_pkg::out_item_t got);
      rkfs_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result r=%02h g=%02h b=%02h adv=%0b at %0t",
                   got.red_out, got.green_out, got.blue_out, got.advanced, $time);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.advanced !== want.advanced) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result %0d expected r=%02h g=%02h b=%02h adv=%0b, got %02h %02h %02h %0b",
                   checked, want.red_out, want.green_out, want.blue_out, want.advanced,
                   got.red_out, got.green_out, got.blue_out, got.advanced);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  rkfs_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  rkfs_pkg::out_item_t out_data;

  fade_scoreboard sb;
  bit          calm;
  int unsigned in_accepted;
  int unsigned idle_cycles = 0;

  rgb_keyframe_fade_sequencer_core #(.ENTRIES(DEPTH)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic level_t rand_step();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10) return 8'd0;
    if (p < 55) return level_t'($urandom_range(12, 1));
    return level_t'($urandom);
  endfunction

  function automatic rkfs_pkg::in_item_t random_item();
    rkfs_pkg::in_item_t it;
    int unsigned p;
    it.entry_index = idx_t'($urandom);
    it.red = level_t'($urandom);
    it.green = level_t'($urandom);
    it.blue = level_t'($urandom);
    it.red_step = rand_step();
    it.green_step = rand_step();
    it.blue_step = rand_step();
    it.seq_first = idx_t'($urandom);
    if ($urandom_range(3) == 0) it.seq_last = idx_t'($urandom);
    else it.seq_last = idx_t'(it.seq_first + $urandom_range(3));
    p = $urandom_range(99);
    if (p < 8) it.action = rkfs_pkg::ACT_WRITE;
    else if (p < 14) it.action = rkfs_pkg::ACT_SELECT;
    else if (p < 17) it.action = ACT_UNUSED;
    else it.action = rkfs_pkg::ACT_TICK;
    return it;
  endfunction

  // Never let a tick or select read a keyframe that has not been loaded yet.
  function automatic rkfs_pkg::in_item_t safe_item(rkfs_pkg::in_item_t it);
    int need;
    need = sb.missing_entry(it);
    if (need < 0) return it;
    it = random_item();
    it.action = rkfs_pkg::ACT_WRITE;
    it.entry_index = idx_t'(need);
    return it;
  endfunction

  function automatic rkfs_pkg::in_item_t mk_write(idx_t e, level_t r, level_t g, level_t b,
                                                  level_t rs, level_t gs, level_t bs);
    rkfs_pkg::in_item_t it;
    it = '0;
    it.action = rkfs_pkg::ACT_WRITE;
    it.entry_index = e;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.red_step = rs;
    it.green_step = gs;
    it.blue_step = bs;
    return it;
  endfunction

  function automatic rkfs_pkg::in_item_t mk_select(idx_t first, idx_t last);
    rkfs_pkg::in_item_t it;
    it = '0;
    it.action = rkfs_pkg::ACT_SELECT;
    it.seq_first = first;
    it.seq_last = last;
    return it;
  endfunction

  function automatic rkfs_pkg::in_item_t mk_tick();
    rkfs_pkg::in_item_t it;
    it = '0;
    it.action = rkfs_pkg::ACT_TICK;
    return it;
  endfunction

  task automatic send_item(input rkfs_pkg::in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
    in_accepted++;
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  initial begin
    bit pressure_done;
    pressure_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!pressure_done && in_accepted >= PRESSURE_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        pressure_done = 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rkfs_pkg::in_item_t it;
    rkfs_pkg::in_item_t directed [$];
    int unsigned counted;
    int unsigned errors;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    in_accepted = 0;
    sb = new();

    directed.push_back(mk_write(5'd0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01));
    directed.push_back(mk_write(5'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk_tick());
    directed.push_back(mk_tick());
    it = '1;
    it.action = ACT_UNUSED;
    directed.push_back(it);
    directed.push_back(mk_write(5'd31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(mk_select(5'd31, 5'd0));
    directed.push_back(mk_tick());
    directed.push_back(mk_tick());
    directed.push_back(mk_select(5'd0, 5'd1));
    directed.push_back(mk_tick());
    directed.push_back(mk_write(5'd2, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h02, 8'h00));
    directed.push_back(mk_write(5'd3, 8'hFF, 8'h00, 8'h80, 8'h10, 8'h10, 8'h10));
    directed.push_back(mk_select(5'd1, 5'd3));
    directed.push_back(mk_tick());
    directed.push_back(mk_tick());
    directed.push_back(mk_tick());
    directed.push_back(mk_write(5'd4, 8'h10, 8'h20, 8'h30, 8'h08, 8'h00, 8'hFF));
    directed.push_back(mk_write(5'd5, 8'h20, 8'h20, 8'h31, 8'h00, 8'h00, 8'h00));
    directed.push_back(mk_select(5'd4, 5'd4));
    directed.push_back(mk_tick());
    directed.push_back(mk_tick());
    directed.push_back(mk_write(5'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(mk_select(5'd31, 5'd31));
    directed.push_back(mk_tick());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) send_item(safe_item(directed[k]));

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      calm = (counted >= 250 && counted < 340);
      it = safe_item(random_item());
      if (it.action != ACT_UNUSED) counted++;
      send_item(it);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    errors = sb.mismatches + sb.pending.size();
    $display("tb: %0d transactions in (%0d ticks, %0d writes, %0d selects, %0d unused codes)",
             in_accepted, sb.ticks, sb.writes, sb.selects, sb.ignored);
    $display("tb: %0d results checked, %0d advances, one output hold-off of %0d cycles",
             sb.checked, sb.advances, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
